[hdl/sps_pkg.sv]
// Shared types and constants for the sorted pair key search block.
package sps_pkg;

   // Field widths fixed by the item format.
   localparam int INDEX_W    = 10;
   localparam int KEY_W      = 32;
   localparam int REDIRECT_W = 31;
   localparam int COUNT_W    = 11;

   // Default table depth and the widest depth the bound fields can carry.
   localparam int TABLE_DEPTH_DEFAULT = 1024;
   localparam int TABLE_DEPTH_MAX     = 1048576;
   localparam int BOUND_W             = $clog2(TABLE_DEPTH_MAX + 1) + 1;

   // Action codes of a request beat.
   typedef enum logic {
      ACTION_WRITE  = 1'b0,
      ACTION_LOOKUP = 1'b1
   } action_type;

   // One item as it travels down the search pipeline.
   typedef struct packed {
      logic                         valid;
      action_type                   action;
      logic [INDEX_W-1:0]           entry_index;
      logic [KEY_W-1:0]             key_source;
      logic [KEY_W-1:0]             key_destination;
      logic [REDIRECT_W-1:0]        redirect_value;
      logic signed [BOUND_W-1:0]    search_low;
      logic signed [BOUND_W-1:0]    search_high;
      logic                         done;
      logic                         hit;
      logic [REDIRECT_W-1:0]        redirect;
   } item_type;

endpackage

[hdl/sps_if.sv]
// Channel interfaces for requests, responses and the count register write.
interface sps_req_if;
   logic                                valid;
   logic                                ready;
   sps_pkg::action_type                 action;
   logic [sps_pkg::INDEX_W-1:0]         entry_index;
   logic [sps_pkg::KEY_W-1:0]           key_source;
   logic [sps_pkg::KEY_W-1:0]           key_destination;
   logic [sps_pkg::REDIRECT_W-1:0]      redirect_value;
   modport source (output valid, action, entry_index, key_source, key_destination,
                   redirect_value, input ready);
   modport sink (input valid, action, entry_index, key_source, key_destination,
                 redirect_value, output ready);
endinterface

interface sps_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                found;
   logic [sps_pkg::REDIRECT_W-1:0]      redirect_index;
   modport source (output valid, found, redirect_index, input ready);
   modport sink (input valid, found, redirect_index, output ready);
endinterface

interface sps_csr_if;
   logic                                valid;
   logic                                ready;
   logic [sps_pkg::COUNT_W-1:0]         data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

[hdl/sorted_pair_key_search.sv]
// Top level of the sorted pair key search block.
// Path: entry register, each step's probe and item registers, then the response register.
// Throughput: one beat per cycle unless stalled; each halving step owns its own table copy.
// Write beats produce no response; they update each step's copy as they pass it.
// A stalled response stalls the whole pipeline; nothing is dropped or repeated.
// Reset clears the entry count and all valid bits; table contents stay undefined.
module sorted_pair_key_search #(
   parameter int TABLE_DEPTH = sps_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   sps_req_if.sink   req_ch,
   sps_rsp_if.source rsp_ch,
   sps_csr_if.sink   csr_ch
);
   localparam int LEVELS = $clog2(TABLE_DEPTH + 1);
   localparam int BW     = sps_pkg::BOUND_W;

   logic [sps_pkg::COUNT_W-1:0]    count_ff;
   logic signed [BW-1:0]           used;
   logic                           advance;
   sps_pkg::item_type              entry_ff;
   sps_pkg::item_type              stage [LEVELS+1];
   logic                           rsp_valid_ff;
   logic                           found_ff;
   logic [sps_pkg::REDIRECT_W-1:0] redirect_ff;

   // Entry count register.
   assign csr_ch.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_ch.valid) begin
         count_ff <= csr_ch.data;
      end
   end

   always_comb begin
      if (32'(count_ff) > 32'(TABLE_DEPTH)) begin
         used = BW'(TABLE_DEPTH);
      end else begin
         used = BW'(count_ff);
      end
   end

   // The pipeline moves whenever the response register can take a beat.
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   // Entry stage: set up the initial bounds.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (advance) begin
         entry_ff.valid <= req_ch.valid;
      end
      if (advance) begin
         entry_ff.action          <= req_ch.action;
         entry_ff.entry_index     <= req_ch.entry_index;
         entry_ff.key_source      <= req_ch.key_source;
         entry_ff.key_destination <= req_ch.key_destination;
         entry_ff.redirect_value  <= req_ch.redirect_value;
         entry_ff.search_low      <= '0;
         entry_ff.search_high     <= used - BW'(1);
         entry_ff.done            <= (used == '0);
         entry_ff.hit             <= 1'b0;
         entry_ff.redirect        <= '0;
      end
   end

   assign stage[0] = entry_ff;

   // Halving steps.
   for (genvar g = 0; g < LEVELS; g++) begin : g_level
      sps_level #(
         .TABLE_DEPTH(TABLE_DEPTH)
      ) u_level (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .item_in (stage[g]),
         .item_out(stage[g+1])
      );
   end

   // Response register: only lookups answer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= stage[LEVELS].valid &&
                         (stage[LEVELS].action == sps_pkg::ACTION_LOOKUP);
      end
      if (advance) begin
         found_ff    <= stage[LEVELS].hit;
         redirect_ff <= stage[LEVELS].hit ? stage[LEVELS].redirect : '0;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.found          = found_ff;
   assign rsp_ch.redirect_index = redirect_ff;
endmodule

[hdl/sps_level.sv]
// One halving step of the search: a table copy, a probe read and a key compare.
module sps_level #(
   parameter int TABLE_DEPTH = sps_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  sps_pkg::item_type item_in,
   output sps_pkg::item_type item_out
);
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int BW = sps_pkg::BOUND_W;

   // Table copy owned by this step.
   logic [sps_pkg::KEY_W-1:0]      src_mem [TABLE_DEPTH];
   logic [sps_pkg::KEY_W-1:0]      dst_mem [TABLE_DEPTH];
   logic [sps_pkg::REDIRECT_W-1:0] red_mem [TABLE_DEPTH];

   sps_pkg::item_type              probe_ff;
   logic                           active_ff;
   logic signed [BW-1:0]           mid_ff;
   logic [sps_pkg::KEY_W-1:0]      rd_src_ff;
   logic [sps_pkg::KEY_W-1:0]      rd_dst_ff;
   logic [sps_pkg::REDIRECT_W-1:0] rd_red_ff;
   sps_pkg::item_type              item_ff;
   sps_pkg::item_type              item_in_nxt;

   logic signed [BW-1:0]           mid_in;
   logic                           active_in;
   logic                           write_hit;
   logic [AW-1:0]                  rd_addr;
   logic [AW-1:0]                  wr_addr;

   // Probe position and whether this item still searches.
   always_comb begin
      mid_in    = (item_in.search_low + item_in.search_high) >>> 1;
      active_in = item_in.valid && (item_in.action == sps_pkg::ACTION_LOOKUP) &&
                  !item_in.done && (item_in.search_low <= item_in.search_high);
      rd_addr   = AW'(unsigned'(mid_in));
      wr_addr   = AW'(item_in.entry_index);
      write_hit = item_in.valid && (item_in.action == sps_pkg::ACTION_WRITE) &&
                  (32'(item_in.entry_index) < 32'(TABLE_DEPTH));
   end

   // Table write as the write beat passes, probe read for lookups.
   always_ff @(posedge clock) begin
      if (advance && write_hit) begin
         src_mem[wr_addr] <= item_in.key_source;
         dst_mem[wr_addr] <= item_in.key_destination;
         red_mem[wr_addr] <= item_in.redirect_value;
      end
      if (advance && active_in) begin
         rd_src_ff <= src_mem[rd_addr];
         rd_dst_ff <= dst_mem[rd_addr];
         rd_red_ff <= red_mem[rd_addr];
      end
   end

   // First register stage of the step.
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.valid <= 1'b0;
      end else if (advance) begin
         probe_ff <= item_in;
      end
      if (advance) begin
         active_ff <= active_in;
         mid_ff    <= mid_in;
      end
   end

   // Compare the probed entry and narrow the bounds, or record a hit on a match.
   always_comb begin
      item_in_nxt = probe_ff;
      if (active_ff) begin
         if ((rd_src_ff < probe_ff.key_source) ||
             ((rd_src_ff == probe_ff.key_source) &&
              (rd_dst_ff < probe_ff.key_destination))) begin
            item_in_nxt.search_low = mid_ff + BW'(1);
         end else if ((rd_src_ff > probe_ff.key_source) ||
                      (rd_dst_ff > probe_ff.key_destination)) begin
            item_in_nxt.search_high = mid_ff - BW'(1);
         end else begin
            item_in_nxt.done     = 1'b1;
            item_in_nxt.hit      = 1'b1;
            item_in_nxt.redirect = rd_red_ff;
         end
      end
   end

   // Second register stage of the step.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (advance) begin
         item_ff <= item_in_nxt;
      end
   end

   assign item_out = item_ff;
endmodule

[hdl/sps_checker.sv]
// Port-level checks for the sorted pair key search block, bound to the top level.
module sps_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_found,
   input logic [sps_pkg::REDIRECT_W-1:0]     rsp_redirect_index
);
   // A stalled response beat stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat withdrawn while stalled");

   // A miss always carries a zero redirect index.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_redirect_index == '0)
      else $error("miss with nonzero redirect index");

   // The request side is held off only while a response beat is stalled.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without a stalled response");

   // No response can appear right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");
endmodule

bind sorted_pair_key_search sps_checker u_sps_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_found         (rsp_ch.found),
   .rsp_redirect_index(rsp_ch.redirect_index)
);
